[hdl/gcg_pkg.sv]
// Shared constants, tables and types of the gradient color generator.
package gcg_pkg;

	localparam int MAX_COLORS   = 64;
	localparam int GAMMA_TENTHS = 24;
	localparam int FRAC_BITS    = 16;

	localparam int IDX_W  = 6;
	localparam int CNT_W  = 7;
	localparam int PAL_W  = 3;
	localparam int CH_W   = 8;
	localparam int CFG_W  = 7;
	localparam int SEC_W  = 2;
	localparam int D_W    = 6;

	// index * (stops - 1) fits in NUM_W bits; reciprocal of the divisor in Q(RECIP_SHIFT)
	localparam int NUM_W       = IDX_W + 1;
	localparam int RECIP_SHIFT = FRAC_BITS + NUM_W + D_W;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = NUM_W + RECIP_W;
	localparam int POS_W       = FRAC_BITS + SEC_W;
	localparam int BLEND_W     = CH_W + FRAC_BITS + 1;

	// Q30 arithmetic used while building the tables
	localparam int          QBITS = 30;
	localparam logic [63:0] QONE  = 64'd1 << QBITS;

	// register indexes
	localparam logic REG_PALETTE = 1'b0;
	localparam logic REG_COUNT   = 1'b1;

	localparam logic [PAL_W-1:0] PAL_RESET   = 3'd0;
	localparam logic [CNT_W-1:0] COUNT_RESET = 7'd2;

	typedef logic [2:0][CH_W-1:0] rgb_t;
	typedef logic [0:7][0:2][0:2][CH_W-1:0] stops_t;
	typedef logic [0:255][30:0] lin_t;
	typedef logic [0:255][CH_W-1:0] byte_tab_t;
	typedef logic [0:63][RECIP_W-1:0] recip_tab_t;

	// stop colors per palette: {r, g, b} of stop 0, 1, 2
	localparam stops_t STOP_RGB = '{
		'{'{8'd255, 8'd0,   8'd0  }, '{8'd0,   8'd255, 8'd0  }, '{8'd0, 8'd0, 8'd0  }},
		'{'{8'd255, 8'd0,   8'd0  }, '{8'd0,   8'd0,   8'd255}, '{8'd0, 8'd0, 8'd0  }},
		'{'{8'd255, 8'd128, 8'd0  }, '{8'd131, 8'd0,   8'd255}, '{8'd0, 8'd0, 8'd0  }},
		'{'{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd0,   8'd255}, '{8'd0, 8'd0, 8'd0  }},
		'{'{8'd255, 8'd0,   8'd255}, '{8'd128, 8'd255, 8'd0  }, '{8'd0, 8'd0, 8'd0  }},
		'{'{8'd64,  8'd224, 8'd208}, '{8'd255, 8'd128, 8'd0  }, '{8'd255, 8'd0, 8'd255}},
		'{'{8'd255, 8'd128, 8'd0  }, '{8'd128, 8'd255, 8'd0  }, '{8'd0, 8'd0, 8'd255}},
		'{'{8'd0,   8'd0,   8'd0  }, '{8'd0,   8'd0,   8'd0  }, '{8'd0, 8'd0, 8'd0  }}
	};

	// number of segments (stops - 1) per palette
	localparam logic [0:7][SEC_W-1:0] STOP_SEC = '{
		2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd0
	};

	// n truncated Q30 self-multiplies starting from one
	function automatic logic [63:0] qpow(input logic [63:0] x, input int n);
		logic [63:0] r;
		r = QONE;
		for (int i = 0; i < n; i++) begin
			r = (r * x) >> QBITS;
		end
		return r;
	endfunction

	// y/255 raised to the power 1.0 in the gamma's tenth-power domain
	function automatic lin_t build_lin10();
		lin_t        t;
		logic [63:0] q;
		for (int h = 0; h < 16; h++) begin
			for (int l = 0; l < 16; l++) begin
				q = (64'(h * 16 + l) << QBITS) / 64'd255;
				t[h * 16 + l] = 31'(qpow(q, 10));
			end
		end
		return t;
	endfunction

	// sRGB code to linear code: largest y with lin10[y] <= b^gamma
	function automatic logic [CH_W-1:0] inv_srgb(input logic [CH_W-1:0] c, input lin_t lin);
		logic [63:0]     b;
		logic [63:0]     p;
		logic [CH_W-1:0] best;
		best = '0;
		if (c > 8'd10) begin
			b = ((64'(c) * 64'd1000 + 64'd14025) << QBITS) / 64'd269025;
			p = qpow(b, GAMMA_TENTHS);
			for (int h = 0; h < 16; h++) begin
				for (int l = 0; l < 16; l++) begin
					if ((h * 16 + l) > 0 && 64'(lin[h * 16 + l]) <= p) begin
						best = best + 8'd1;
					end
				end
			end
		end
		return best;
	endfunction

	// linear codes of every stop color
	function automatic stops_t build_inv_stop();
		lin_t   lin;
		stops_t t;
		lin = build_lin10();
		for (int p = 0; p < 8; p++) begin
			for (int s = 0; s < 3; s++) begin
				for (int k = 0; k < 3; k++) begin
					t[p][s][k] = inv_srgb(STOP_RGB[p][s][k], lin);
				end
			end
		end
		return t;
	endfunction

	// linear code to sRGB code: output o is reached when the sRGB threshold
	// of o, raised to the gamma, stays at or below the linear value
	function automatic byte_tab_t build_fwd();
		lin_t        lin;
		lin_t        thr;
		byte_tab_t   t;
		logic [63:0] tv;
		logic [7:0]  n;
		lin = build_lin10();
		thr = '0;
		for (int h = 0; h < 16; h++) begin
			for (int l = 0; l < 16; l++) begin
				if ((h * 16 + l) > 0) begin
					tv = (((64'(h * 16 + l) * 64'd1000 + 64'd14025) << QBITS) + 64'd269024)
						/ 64'd269025;
					thr[h * 16 + l] = 31'(qpow(tv, GAMMA_TENTHS));
				end
			end
		end
		for (int vh = 0; vh < 16; vh++) begin
			for (int vl = 0; vl < 16; vl++) begin
				n = '0;
				for (int h = 0; h < 16; h++) begin
					for (int l = 0; l < 16; l++) begin
						if ((h * 16 + l) > 0 && thr[h * 16 + l] <= lin[vh * 16 + vl]) begin
							n = n + 8'd1;
						end
					end
				end
				t[vh * 16 + vl] = n;
			end
		end
		t[0] = '0;
		return t;
	endfunction

	// ceil(2^RECIP_SHIFT / d) by long division; zero for d = 0
	function automatic recip_tab_t build_recip();
		recip_tab_t         t;
		logic [RECIP_W-1:0] n;
		logic [RECIP_W-1:0] q;
		logic [D_W:0]       rem;
		t[0] = '0;
		for (int d = 1; d < 64; d++) begin
			n   = (RECIP_W'(1) << RECIP_SHIFT) + RECIP_W'(d - 1);
			q   = '0;
			rem = '0;
			for (int i = RECIP_W - 1; i >= 0; i--) begin
				rem = {rem[D_W-1:0], n[i]};
				if (rem >= (D_W + 1)'(d)) begin
					rem  = rem - (D_W + 1)'(d);
					q[i] = 1'b1;
				end
			end
			t[d] = q;
		end
		return t;
	endfunction

	localparam stops_t     INV_STOP  = build_inv_stop();
	localparam byte_tab_t  FWD_TAB   = build_fwd();
	localparam recip_tab_t RECIP_TAB = build_recip();

	// position stage result
	typedef struct packed {
		logic [PAL_W-1:0] pal;
		logic [SEC_W-1:0] sec;
		logic             err;
		logic [POS_W-1:0] pos;
	} pos_t;

	// blend stage result: linear code, or the final stop itself
	typedef struct packed {
		logic err;
		logic last;
		rgb_t col;
	} mix_t;

endpackage

[hdl/gcg_pos.sv]
// Position stages: segment count and reciprocal lookup, then position multiply.
module gcg_pos
	import gcg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [PAL_W-1:0] palette_select,
	input  logic [CNT_W-1:0] color_count,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [IDX_W-1:0] color_index,
	output logic             pos_valid,
	input  logic             pos_ready,
	output pos_t             pos_out
);

	logic               vld_s1;
	logic [PAL_W-1:0]   pal_s1;
	logic [SEC_W-1:0]   sec_s1;
	logic               err_s1;
	logic [NUM_W-1:0]   num_s1;
	logic [RECIP_W-1:0] recip_s1;
	logic               rdy_s1;

	logic               vld_s2;
	pos_t               pos_s2;
	logic               rdy_s2;

	logic [SEC_W-1:0]   sec;
	logic [D_W-1:0]     div;
	logic [PROD_W-1:0]  prod;

	// divisor is count - 1, with counts above the maximum taken as the maximum
	always_comb begin
		sec = STOP_SEC[palette_select];
		if (color_count > CNT_W'(MAX_COLORS)) begin
			div = D_W'(MAX_COLORS - 1);
		end else begin
			div = D_W'(color_count - CNT_W'(1));
		end
	end

	assign rdy_s2   = !vld_s2 || pos_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			pal_s1   <= palette_select;
			sec_s1   <= sec;
			err_s1   <= {1'b0, color_index} >= color_count;
			num_s1   <= NUM_W'({1'b0, color_index}) * NUM_W'(sec);
			recip_s1 <= RECIP_TAB[div];
		end
	end

	// stage 2: pos = num * 2^FRAC_BITS / div through the exact reciprocal
	assign prod = PROD_W'(num_s1) * PROD_W'(recip_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			pos_s2.pal <= pal_s1;
			pos_s2.sec <= sec_s1;
			pos_s2.err <= err_s1;
			pos_s2.pos <= prod[RECIP_SHIFT-FRAC_BITS +: POS_W];
		end
	end

	assign pos_valid = vld_s2;
	assign pos_out   = pos_s2;

endmodule

[hdl/gcg_mix.sv]
// Blend stage: linear-light interpolation between the two stops of a segment.
module gcg_mix
	import gcg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic pos_valid,
	output logic pos_ready,
	input  pos_t pos_in,
	output logic mix_valid,
	input  logic mix_ready,
	output mix_t mix_out
);

	logic                 vld_s3;
	mix_t                 mix_s3;
	logic                 rdy_s3;

	logic [SEC_W-1:0]     seg;
	logic [FRAC_BITS-1:0] frac;
	logic                 last;
	logic [SEC_W-1:0]     sidx;
	logic [SEC_W-1:0]     nidx;
	logic [FRAC_BITS:0]   wa;
	logic [BLEND_W-1:0]   sum [3];
	rgb_t                 col;

	// segment, weight and stop indexes
	always_comb begin
		seg  = pos_in.pos[FRAC_BITS +: SEC_W];
		frac = pos_in.pos[FRAC_BITS-1:0];
		last = seg >= pos_in.sec;
		sidx = last ? pos_in.sec : seg;
		nidx = (sidx == 2'd0) ? 2'd1 : 2'd2;
		wa   = (FRAC_BITS + 1)'(1) << FRAC_BITS;
		wa   = wa - {1'b0, frac};
	end

	// per channel: (a * (1 - f) + b * f) truncated
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum[k] = BLEND_W'(INV_STOP[pos_in.pal][sidx][k]) * BLEND_W'(wa)
				+ BLEND_W'(INV_STOP[pos_in.pal][nidx][k]) * BLEND_W'({1'b0, frac});
			col[k] = last ? STOP_RGB[pos_in.pal][pos_in.sec][k]
				: sum[k][FRAC_BITS +: CH_W];
		end
	end

	assign rdy_s3    = !vld_s3 || mix_ready;
	assign pos_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= pos_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && pos_valid) begin
			mix_s3.err  <= pos_in.err;
			mix_s3.last <= last;
			mix_s3.col  <= col;
		end
	end

	assign mix_valid = vld_s3;
	assign mix_out   = mix_s3;

endmodule

[hdl/gcg_out.sv]
// Output stage: forward sRGB lookup, error masking and the output register.
module gcg_out
	import gcg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic mix_valid,
	output logic mix_ready,
	input  mix_t mix_in,
	output logic out_valid,
	input  logic out_ready,
	output rgb_t col_out,
	output logic err_out
);

	logic vld_s4;
	rgb_t col_s4;
	logic err_s4;
	logic rdy_s4;
	rgb_t col;

	// errors give black, the final stop passes unchanged, blends go back to sRGB
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (mix_in.err) begin
				col[k] = '0;
			end else if (mix_in.last) begin
				col[k] = mix_in.col[k];
			end else begin
				col[k] = FWD_TAB[mix_in.col[k]];
			end
		end
	end

	assign rdy_s4    = !vld_s4 || out_ready;
	assign mix_ready = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (rdy_s4) begin
			vld_s4 <= mix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && mix_valid) begin
			col_s4 <= col;
			err_s4 <= mix_in.err;
		end
	end

	assign out_valid = vld_s4;
	assign col_out   = col_s4;
	assign err_out   = err_s4;

endmodule

[hdl/gamma_correct_gradient_color.sv]
// Top level of the gradient color generator with linear-light blending.
//
// Usage: a request carries color_index on the in_valid / in_ready channel and
// returns one color (red, green, blue, index_error) on out_valid / out_ready.
// The gradient spans color_count colors over the stops of the palette chosen
// by palette_select; both are set through cfg_write / cfg_index / cfg_data
// (index 0 palette, 1 count) while no request is in flight.
// Pipeline: a request passes through four register stages (position, multiply,
// blend, sRGB lookup), each with its own valid bit.
// Throughput: one request per cycle; a new request is taken every cycle while
// out_ready is high. The position multiply (7 x 30 bits) sets the longest stage.
// Stall: when out_ready is low the result holds in the output register and
// empty stages ahead of it keep filling, so in_ready drops only once all four
// stages hold a request.
// Reset: arst_n clears all valid bits and sets palette 0 and a count of 2.
// An index at or past the count returns black with index_error set.
module gamma_correct_gradient_color
	import gcg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [IDX_W-1:0] color_index,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CH_W-1:0]  red,
	output logic [CH_W-1:0]  green,
	output logic [CH_W-1:0]  blue,
	output logic             index_error
);

	logic [PAL_W-1:0] palette_select_q;
	logic [CNT_W-1:0] color_count_q;

	logic pos_valid;
	logic pos_ready;
	pos_t pos_data;
	logic mix_valid;
	logic mix_ready;
	mix_t mix_data;
	rgb_t col;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_select_q <= PAL_RESET;
			color_count_q    <= COUNT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PALETTE: palette_select_q <= cfg_data[PAL_W-1:0];
				REG_COUNT:   color_count_q    <= cfg_data[CNT_W-1:0];
				default:     ;
			endcase
		end
	end

	gcg_pos u_pos (
		.clk            (clk),
		.arst_n         (arst_n),
		.palette_select (palette_select_q),
		.color_count    (color_count_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.color_index    (color_index),
		.pos_valid      (pos_valid),
		.pos_ready      (pos_ready),
		.pos_out        (pos_data)
	);

	gcg_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.pos_valid (pos_valid),
		.pos_ready (pos_ready),
		.pos_in    (pos_data),
		.mix_valid (mix_valid),
		.mix_ready (mix_ready),
		.mix_out   (mix_data)
	);

	gcg_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.mix_valid (mix_valid),
		.mix_ready (mix_ready),
		.mix_in    (mix_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.col_out   (col),
		.err_out   (index_error)
	);

	assign red   = col[0];
	assign green = col[1];
	assign blue  = col[2];

endmodule

[hdl/gcg_checker.sv]
// Port-level assertions for the gradient color generator, bound to the top level.
module gcg_checker
	import gcg_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [CH_W-1:0]  red,
	input logic [CH_W-1:0]  green,
	input logic [CH_W-1:0]  blue,
	input logic             index_error
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its color
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({red, green, blue, index_error}))
		else $error("result changed while stalled");

	// an out-of-range index returns black
	a_err_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_error |-> red == '0 && green == '0 && blue == '0)
		else $error("index error with nonzero color");

	// a draining output never blocks new requests
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("request blocked while output drains");

endmodule

bind gamma_correct_gradient_color gcg_checker u_checker (.*);

[bench/tb_gamma_correct_gradient_color.sv]
`timescale 1ns / 100ps
// Testbench of the gradient color generator: predicted sRGB colors checked per request.
module tb_gamma_correct_gradient_color;
	import gcg_pkg::*;

	localparam int CLK_HALF   = 10;
	localparam int GAMMA_X10  = 24;
	localparam int POS_FRAC   = 16;
	localparam int COUNT_CAP  = 64;
	localparam int LATENCY    = 4;
	localparam int PHASES     = 16;
	localparam int PHASE_REQS = 97;
	localparam int MAX_SHOWN  = 100;

	typedef enum logic [2:0] {
		PAL_RED_GREEN,
		PAL_RED_BLUE,
		PAL_ORANGE_VIOLET,
		PAL_CYAN_MAGENTA,
		PAL_MAGENTA_LIME,
		PAL_CYAN_ORANGE_MAGENTA,
		PAL_ORANGE_GREEN_BLUE,
		PAL_BLACK
	} palette_e;

	typedef struct packed {
		logic [IDX_W-1:0] req_index;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic             index_error;
	} color_result_t;

	// predicted gradient colors, checked in request order
	class gradient_scoreboard;
		bit [7:0]      to_linear [256];
		bit [7:0]      to_srgb [256];
		logic [2:0]    palette;
		logic [6:0]    count;
		color_result_t expected_q[$];
		int            errors;

		function bit [63:0] q30_power(bit [63:0] x, int n);
			bit [63:0] r;
			r = 64'd1 << 30;
			for (int i = 0; i < n; i++) begin
				r = (r * x) >> 30;
			end
			return r;
		endfunction

		// both sRGB tables, built the slow exact way
		function new();
			bit [63:0] tenth_pow [256];
			bit [63:0] base;
			bit [63:0] limit;
			bit [63:0] lo;
			bit [63:0] hi;
			bit [63:0] mid;
			bit [63:0] num;
			bit [63:0] sub;
			bit [63:0] code;
			int        best;
			palette = PAL_RED_GREEN;
			count   = 7'd2;
			errors  = 0;
			for (int y = 0; y < 256; y++) begin
				tenth_pow[y] = q30_power((64'(y) << 30) / 64'd255, 10);
			end
			// sRGB code to linear code; the linear toe truncates to zero
			for (int c = 0; c < 256; c++) begin
				best = 0;
				if (c > 10) begin
					base  = ((64'(c) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
					limit = q30_power(base, GAMMA_X10);
					for (int y = 0; y < 256; y++) begin
						if (tenth_pow[y] <= limit) best = y;
					end
				end
				to_linear[c] = best[7:0];
			end
			// linear code to sRGB code: largest root, then undo the offset
			to_srgb[0] = 8'd0;
			sub = 64'd14025 << 30;
			for (int c = 1; c < 256; c++) begin
				lo = 64'd0;
				hi = 64'd1 << 30;
				while (lo < hi) begin
					mid = (lo + hi + 64'd1) / 64'd2;
					if (q30_power(mid, GAMMA_X10) <= tenth_pow[c]) lo = mid;
					else hi = mid - 64'd1;
				end
				num = 64'd269025 * lo;
				if (num <= sub) code = 64'd0;
				else code = (num - sub) / (64'd1000 << 30);
				if (code > 64'd255) code = 64'd255;
				to_srgb[c] = code[7:0];
			end
		endfunction

		function int segment_count(logic [2:0] pal);
			case (palette_e'(pal))
				PAL_CYAN_ORANGE_MAGENTA, PAL_ORANGE_GREEN_BLUE: return 2;
				PAL_BLACK: return 0;
				default: return 1;
			endcase
		endfunction

		// {r, g, b} of stop s in the palette
		function logic [23:0] stop_color(logic [2:0] pal, int s);
			logic [71:0] row;
			case (palette_e'(pal))
				PAL_RED_GREEN:           row = {24'hFF0000, 24'h00FF00, 24'h000000};
				PAL_RED_BLUE:            row = {24'hFF0000, 24'h0000FF, 24'h000000};
				PAL_ORANGE_VIOLET:       row = {24'hFF8000, 24'h8300FF, 24'h000000};
				PAL_CYAN_MAGENTA:        row = {24'h00FFFF, 24'hFF00FF, 24'h000000};
				PAL_MAGENTA_LIME:        row = {24'hFF00FF, 24'h80FF00, 24'h000000};
				PAL_CYAN_ORANGE_MAGENTA: row = {24'h40E0D0, 24'hFF8000, 24'hFF00FF};
				PAL_ORANGE_GREEN_BLUE:   row = {24'hFF8000, 24'h80FF00, 24'h0000FF};
				default:                 row = '0;
			endcase
			return row[71 - 24 * s -: 24];
		endfunction

		function void set_register(logic idx, logic [CFG_W-1:0] value);
			if (idx == REG_PALETTE) palette = value[2:0];
			else count = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// color for one accepted request
		function void note_request(logic [IDX_W-1:0] idx);
			color_result_t want;
			bit [63:0]     eff;
			bit [63:0]     segs;
			bit [63:0]     pos;
			bit [63:0]     seg;
			bit [63:0]     frac;
			bit [63:0]     a;
			bit [63:0]     b;
			bit [63:0]     v;
			logic [23:0]   lo_stop;
			logic [23:0]   hi_stop;
			logic [23:0]   col;
			eff  = (count > COUNT_CAP) ? 64'(COUNT_CAP) : 64'(count);
			segs = 64'(segment_count(palette));
			col  = '0;
			want = '0;
			want.req_index = idx;
			if (64'(idx) >= eff) begin
				want.index_error = 1'b1;
			end else begin
				if (eff == 64'd1) pos = 64'd0;
				else pos = ((64'(idx) * segs) << POS_FRAC) / (eff - 64'd1);
				seg  = pos >> POS_FRAC;
				frac = pos & ((64'd1 << POS_FRAC) - 64'd1);
				if (seg >= segs) begin
					// last index, or the black palette: stop passes unchanged
					col = stop_color(palette, int'(segs));
				end else begin
					lo_stop = stop_color(palette, int'(seg));
					hi_stop = stop_color(palette, int'(seg) + 1);
					for (int k = 0; k < 3; k++) begin
						a = 64'(to_linear[lo_stop[23 - 8 * k -: 8]]);
						b = 64'(to_linear[hi_stop[23 - 8 * k -: 8]]);
						v = (a * ((64'd1 << POS_FRAC) - frac) + b * frac) >> POS_FRAC;
						col[23 - 8 * k -: 8] = to_srgb[v[7:0]];
					end
				end
			end
			{want.red, want.green, want.blue} = col;
			expected_q.push_back(want);
		endfunction

		task report(string text);
			errors++;
			if (errors <= MAX_SHOWN) $display("%0t mismatch: %s", $time, text);
		endtask

		task check_result(color_result_t got);
			color_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("color %0d/%0d/%0d error %0b with no request pending",
					got.red, got.green, got.blue, got.index_error));
				return;
			end
			want = expected_q.pop_front();
			if (got.red !== want.red)
				report($sformatf("index %0d red %0d, expected %0d",
					want.req_index, got.red, want.red));
			if (got.green !== want.green)
				report($sformatf("index %0d green %0d, expected %0d",
					want.req_index, got.green, want.green));
			if (got.blue !== want.blue)
				report($sformatf("index %0d blue %0d, expected %0d",
					want.req_index, got.blue, want.blue));
			if (got.index_error !== want.index_error)
				report($sformatf("index %0d index_error %0b, expected %0b",
					want.req_index, got.index_error, want.index_error));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_write;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_ready;
	logic [IDX_W-1:0] color_index;
	logic             out_valid;
	logic             out_ready;
	logic [CH_W-1:0]  red;
	logic [CH_W-1:0]  green;
	logic [CH_W-1:0]  blue;
	logic             index_error;

	gradient_scoreboard colors;
	bit                 calm_send;
	bit                 calm_recv;

	gamma_correct_gradient_color i_dut (.*);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// one request; returns at the falling edge after acceptance, valid still up
	task send_index(input logic [IDX_W-1:0] idx);
		int gap;
		gap = calm_send ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		color_index <= idx;
		do @(posedge clk); while (in_ready !== 1'b1);
		colors.note_request(idx);
		@(negedge clk);
	endtask

	// drop valid and wait for every pending color
	task hold_until_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (colors.pending() != 0) @(negedge clk);
	endtask

	task write_reg(input logic idx, input logic [CFG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		colors.set_register(idx, value);
		@(negedge clk);
	endtask

	task reconfigure(input logic [CFG_W-1:0] pal_word, input logic [CFG_W-1:0] cnt_word);
		hold_until_drained();
		if ($urandom_range(0, 1) == 0) begin
			write_reg(REG_PALETTE, pal_word);
			write_reg(REG_COUNT, cnt_word);
		end else begin
			write_reg(REG_COUNT, cnt_word);
			write_reg(REG_PALETTE, pal_word);
		end
	endtask

	// result side: random stall before each color, then check it
	initial begin : color_sink
		color_result_t got;
		int            stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = calm_recv ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got = '0;
			got.red         = red;
			got.green       = green;
			got.blue        = blue;
			got.index_error = index_error;
			colors.check_result(got);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		logic [2:0]       pal;
		logic [CFG_W-1:0] cnt;
		int               eff;
		logic [IDX_W-1:0] idx;
		colors      = new();
		arst_n      = 1'b0;
		cfg_write   = 1'b0;
		cfg_index   = REG_PALETTE;
		cfg_data    = '0;
		in_valid    = 1'b0;
		color_index = '0;
		calm_send   = 1'b0;
		calm_recv   = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers: red to green over two colors, then past the end
		send_index(6'd0);
		send_index(6'd1);
		send_index(6'd2);
		send_index(6'd63);
		// three stops over the largest count
		reconfigure(7'(PAL_CYAN_ORANGE_MAGENTA), 7'd64);
		send_index(6'd0);
		send_index(6'd31);
		send_index(6'd32);
		send_index(6'd62);
		send_index(6'd63);
		// black palette, upper data bits set on the palette write
		reconfigure(7'h78 | 7'(PAL_BLACK), 7'd10);
		send_index(6'd0);
		send_index(6'd5);
		send_index(6'd9);
		send_index(6'd10);
		// single color goes through both tables
		reconfigure(7'(PAL_ORANGE_VIOLET), 7'd1);
		send_index(6'd0);
		send_index(6'd1);
		// zero count: every index is out of range
		reconfigure(7'(PAL_MAGENTA_LIME), 7'd0);
		send_index(6'd0);
		// counts above the cap act as the cap
		reconfigure(7'(PAL_ORANGE_GREEN_BLUE), 7'd127);
		send_index(6'd0);
		send_index(6'd42);
		send_index(6'd63);
		reconfigure(7'h50 | 7'(PAL_CYAN_MAGENTA), 7'd65);
		send_index(6'd21);
		send_index(6'd63);
		reconfigure(7'(PAL_RED_BLUE), 7'd3);
		send_index(6'd1);

		// random phases: each palette, extreme counts first, mixed idling
		for (int phase = 0; phase < PHASES; phase++) begin
			pal = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
			case (phase)
				0: cnt = 7'd64;
				1: cnt = 7'd1;
				2: cnt = 7'd127;
				3: cnt = 7'd2;
				4: cnt = 7'd0;
				5: cnt = 7'd63;
				default: begin
					case ($urandom_range(0, 7))
						0: cnt = 7'd1;
						1: cnt = 7'd64;
						2: cnt = 7'($urandom_range(65, 127));
						default: cnt = 7'($urandom_range(2, 64));
					endcase
				end
			endcase
			reconfigure({4'($urandom_range(0, 15)), pal}, cnt);
			calm_send = (phase % 4 == 1) || ($urandom_range(0, 5) == 0);
			calm_recv = (phase % 4 == 2) || ($urandom_range(0, 5) == 0);
			eff = (cnt > COUNT_CAP) ? COUNT_CAP : int'(cnt);
			for (int i = 0; i < PHASE_REQS; i++) begin
				if (i == PHASE_REQS / 2 && phase % 5 == 3) hold_until_drained();
				if (eff != 0 && $urandom_range(0, 9) < 8) idx = 6'($urandom_range(0, eff - 1));
				else idx = 6'($urandom_range(0, 63));
				send_index(idx);
			end
		end

		hold_until_drained();
		repeat (LATENCY * 4) @(negedge clk);
		if (colors.errors == 0 && colors.pending() == 0) begin
			$display("tb_gamma_correct_gradient_color: clean");
		end else begin
			$display("tb_gamma_correct_gradient_color: errors");
		end
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin : watchdog
		#(10_000_000);
		$display("tb_gamma_correct_gradient_color: errors");
		$finish;
	end

endmodule
